>>> rtl/mexp_pkg.sv
// shared constants and types for the modular exponentiation block
// field widths, prime modulus, barrett constant and state encodings
// no dependencies
package mexp_pkg;

    localparam int BASE_W   = 31;             // base field width
    localparam int EXPO_W   = 63;             // exponent field width
    localparam int RES_W    = 30;             // result width, also width of a residue
    localparam int EXP_BITS = 63;             // exponent bits processed, at most EXPO_W
    localparam int MUL_W    = RES_W + 1;      // operand width of the shared multiplier
    localparam int PROD_W   = 2 * MUL_W;      // product width of the shared multiplier
    localparam int REM_W    = RES_W + 2;      // barrett remainder width, holds up to 3p

    localparam logic [RES_W-1:0]  PRIME      = 30'd1000000007;
    // floor(2^60 / p)
    localparam logic [MUL_W-1:0]  BARRETT_MU = 31'd1152921496;
    localparam logic [BASE_W-1:0] BASE_P1    = 31'd1000000007;
    localparam logic [BASE_W-1:0] BASE_P2    = 31'd2000000014;
    localparam logic [REM_W-1:0]  REM_P1     = 32'd1000000007;
    localparam logic [REM_W-1:0]  REM_P2     = 32'd2000000014;

    // exponentiation sequencer
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_STEP = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_SQR  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    // modular multiplier sequencer
    typedef enum logic [3:0] {
        MM_IDLE = 4'b0001,
        MM_BAR  = 4'b0010,
        MM_QP   = 4'b0100,
        MM_FIX  = 4'b1000
    } t_mm_state;

endpackage

>>> rtl/mexp_modmul.sv
// modular multiplier mod p with one shared 31x31 multiplier and barrett reduction
// steps per product, in order: a*b, quotient estimate, quotient*p, final correction
// depends on mexp_pkg
module mexp_modmul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mexp_pkg::RES_W-1:0] i_op_a,
    input  logic [mexp_pkg::RES_W-1:0] i_op_b,
    output logic                       o_done,
    output logic [mexp_pkg::RES_W-1:0] o_y
);

    mexp_pkg::t_mm_state r_state, n_state;

    logic [2*mexp_pkg::RES_W-1:0] r_x;
    logic [mexp_pkg::RES_W-1:0]   r_q;
    logic [mexp_pkg::REM_W-1:0]   r_qp;
    logic [mexp_pkg::RES_W-1:0]   r_y;
    logic                         r_done;

    logic [mexp_pkg::MUL_W-1:0]   mul_a;
    logic [mexp_pkg::MUL_W-1:0]   mul_b;
    logic [mexp_pkg::PROD_W-1:0]  mul_p;
    logic [mexp_pkg::REM_W-1:0]   rem_raw;
    logic [mexp_pkg::REM_W-1:0]   rem_fix;

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            mexp_pkg::MM_IDLE: begin
                mul_a = {1'b0, i_op_a};
                mul_b = {1'b0, i_op_b};
            end
            mexp_pkg::MM_BAR: begin
                mul_a = r_x[2*mexp_pkg::RES_W-1:mexp_pkg::RES_W-1];
                mul_b = mexp_pkg::BARRETT_MU;
            end
            mexp_pkg::MM_QP: begin
                mul_a = {1'b0, r_q};
                mul_b = {1'b0, mexp_pkg::PRIME};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // remainder is below 3p, at most two subtractions of p
    assign rem_raw = r_x[mexp_pkg::REM_W-1:0] - r_qp;

    always_comb begin
        priority if (rem_raw >= mexp_pkg::REM_P2) begin
            rem_fix = rem_raw - mexp_pkg::REM_P2;
        end else if (rem_raw >= mexp_pkg::REM_P1) begin
            rem_fix = rem_raw - mexp_pkg::REM_P1;
        end else begin
            rem_fix = rem_raw;
        end
    end

    always_comb begin
        unique case (r_state)
            mexp_pkg::MM_IDLE: n_state = i_start ? mexp_pkg::MM_BAR : mexp_pkg::MM_IDLE;
            mexp_pkg::MM_BAR:  n_state = mexp_pkg::MM_QP;
            mexp_pkg::MM_QP:   n_state = mexp_pkg::MM_FIX;
            mexp_pkg::MM_FIX:  n_state = mexp_pkg::MM_IDLE;
            default:           n_state = mexp_pkg::MM_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mexp_pkg::MM_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == mexp_pkg::MM_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mexp_pkg::MM_IDLE: r_x  <= mul_p[2*mexp_pkg::RES_W-1:0];
            mexp_pkg::MM_BAR:  r_q  <= mul_p[2*mexp_pkg::RES_W:mexp_pkg::RES_W+1];
            mexp_pkg::MM_QP:   r_qp <= mul_p[mexp_pkg::REM_W-1:0];
            mexp_pkg::MM_FIX:  r_y  <= rem_fix[mexp_pkg::RES_W-1:0];
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_y    = r_y;

endmodule

>>> rtl/modular_exponentiation.sv
// one item at a time: a new item is taken only in idle, after the last one is finished;
// each modular product holds the one multiplier until it is done
// the finished result waits in an output register while the next item is taken
// reset (i_rst_n low, synchronous) returns the sequencer to idle and drops o_out_valid
module modular_exponentiation (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mexp_pkg::BASE_W-1:0] i_base,
    input  logic [mexp_pkg::EXPO_W-1:0] i_exponent,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mexp_pkg::RES_W-1:0]  o_result
);

    mexp_pkg::t_state r_state, n_state;

    // working registers: accumulator, running square, remaining exponent bits
    logic [mexp_pkg::RES_W-1:0]    r_acc;
    logic [mexp_pkg::RES_W-1:0]    r_sq;
    logic [mexp_pkg::EXP_BITS-1:0] r_exp;

    // output register
    logic                          r_out_valid;
    logic [mexp_pkg::RES_W-1:0]    r_result;

    logic                          in_xfer;
    logic                          out_xfer;
    logic                          out_free;
    logic [mexp_pkg::BASE_W-1:0]   base_red;
    logic                          exp_zero;
    logic                          mm_start;
    logic [mexp_pkg::RES_W-1:0]    mm_a;
    logic                          mm_done;
    logic [mexp_pkg::RES_W-1:0]    mm_y;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;
    // result slot can take a new value this cycle
    assign out_free = !r_out_valid || i_out_ready;
    assign exp_zero = (r_exp == '0);

    // base is below 2^31 < 3p, so at most two subtractions reduce it
    always_comb begin
        priority if (i_base >= mexp_pkg::BASE_P2) begin
            base_red = i_base - mexp_pkg::BASE_P2;
        end else if (i_base >= mexp_pkg::BASE_P1) begin
            base_red = i_base - mexp_pkg::BASE_P1;
        end else begin
            base_red = i_base;
        end
    end

    // a set low bit multiplies into the accumulator first, then the square follows;
    // squaring stops once no higher exponent bit is left
    assign mm_start = (r_state == mexp_pkg::ST_STEP) && !exp_zero;
    assign mm_a     = r_exp[0] ? r_acc : r_sq;

    mexp_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mm_start),
        .i_op_a  (mm_a),
        .i_op_b  (r_sq),
        .o_done  (mm_done),
        .o_y     (mm_y)
    );

    always_comb begin
        unique case (r_state)
            mexp_pkg::ST_IDLE: begin
                n_state = i_in_valid ? mexp_pkg::ST_STEP : mexp_pkg::ST_IDLE;
            end
            mexp_pkg::ST_STEP: begin
                priority if (exp_zero) begin
                    n_state = mexp_pkg::ST_FIN;
                end else if (r_exp[0]) begin
                    n_state = mexp_pkg::ST_MUL;
                end else begin
                    n_state = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL: begin
                n_state = mm_done ? mexp_pkg::ST_STEP : mexp_pkg::ST_MUL;
            end
            mexp_pkg::ST_SQR: begin
                n_state = mm_done ? mexp_pkg::ST_STEP : mexp_pkg::ST_SQR;
            end
            mexp_pkg::ST_FIN: begin
                n_state = out_free ? mexp_pkg::ST_IDLE : mexp_pkg::ST_FIN;
            end
            default: begin
                n_state = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mexp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            priority if (r_state == mexp_pkg::ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        priority if (in_xfer) begin
            r_acc <= mexp_pkg::RES_W'(1);
            r_sq  <= base_red[mexp_pkg::RES_W-1:0];
            r_exp <= i_exponent[mexp_pkg::EXP_BITS-1:0];
        end else if (r_state == mexp_pkg::ST_MUL && mm_done) begin
            r_acc    <= mm_y;
            r_exp[0] <= 1'b0;
        end else if (r_state == mexp_pkg::ST_SQR && mm_done) begin
            r_sq  <= mm_y;
            r_exp <= r_exp >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mexp_pkg::ST_FIN && out_free) begin
            r_result <= r_acc;
        end
    end

    assign o_in_ready  = (r_state == mexp_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

>>> rtl/mexp_checker.sv
// port-level checks for the modular exponentiation block, bound to the top level
// depends on mexp_pkg and modular_exponentiation
module mexp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [mexp_pkg::BASE_W-1:0] i_base,
    input logic [mexp_pkg::EXPO_W-1:0] i_exponent,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [mexp_pkg::RES_W-1:0]  o_result
);

    // a shown result is fully reduced
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result < mexp_pkg::PRIME))
        else $error("result not below the modulus");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_result)))
        else $error("stalled result changed");

    // one item at a time: no transfer right after a transfer
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // zero exponent gives 1 after the step and finish states when the result slot is empty
    a_zero_exponent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_exponent == '0) && !o_out_valid)
            |-> ##3 (o_out_valid && (o_result == mexp_pkg::RES_W'(1))))
        else $error("zero exponent did not give one");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);

>>> tb/sv/tb_modular_exponentiation.sv
// testbench for the modular exponentiation block: directed and random operand transfers,
// each result checked against a square-and-multiply predictor modulo the prime
// depends on mexp_pkg and modular_exponentiation
module tb_modular_exponentiation;

    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    // the limits cover a worst-case item plus random stalls on each side
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 700;
    localparam int RESET_CYCLES = 6;

    localparam logic [63:0]         MOD64    = 64'(PRIME);
    localparam logic [BASE_W-1:0]   BASE_MAX = '1;
    localparam logic [EXPO_W-1:0]   EXPO_MAX = '1;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic [BASE_W-1:0]  i_base      = '0;
    logic [EXPO_W-1:0]  i_exponent  = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b1;
    logic [RES_W-1:0]   o_result;

    // powers still owed by the block, oldest first
    logic [RES_W-1:0]   pending_powers[$];
    int                 error_count = 0;
    int                 quiet_cycles = 0;
    // random idling on both sides while set
    bit                 idle_en = 1'b1;

    modular_exponentiation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // base^exponent mod p, scanning exponent bits from the bottom up
    // operands stay below p < 2^30, so every product fits in 60 bits
    function automatic logic [RES_W-1:0] modpow(input logic [BASE_W-1:0] base,
                                                input logic [EXPO_W-1:0] exponent);
        logic [63:0] acc;
        logic [63:0] sq;
        acc = 64'd1;
        sq  = 64'(base) % MOD64;
        for (int i = 0; i < EXP_BITS; i++) begin
            if (exponent[i]) begin
                acc = (acc * sq) % MOD64;
            end
            sq = (sq * sq) % MOD64;
        end
        return acc[RES_W-1:0];
    endfunction

    // 63 random bits
    function automatic logic [EXPO_W-1:0] rand_exponent();
        return EXPO_W'({$urandom, $urandom});
    endfunction

    // one operand transfer; called at a clock edge and returns at the accepting edge,
    // so valid is either kept high for the next item or dropped for a gap
    task automatic send_operands(input logic [BASE_W-1:0] base,
                                 input logic [EXPO_W-1:0] exponent);
        int unsigned gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_base     <= base;
        i_exponent <= exponent;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // append the owed power at the tail
        pending_powers = {pending_powers, modpow(base, exponent)};
    endtask

    // zero exponent gives 1 for any base, zero and prime multiples included
    task automatic test_zero_exponent();
        send_operands('0, '0);
        send_operands(BASE_MAX, '0);
        send_operands(BASE_P1, '0);
        send_operands(BASE_W'(1), '0);
    endtask

    // corners of both fields and a few bit patterns
    task automatic test_field_extremes();
        send_operands('0, EXPO_W'(1));
        send_operands('0, EXPO_MAX);
        send_operands(BASE_MAX, EXPO_W'(1));
        send_operands(BASE_MAX, EXPO_MAX);
        send_operands(BASE_W'(1), EXPO_MAX);
        send_operands(BASE_W'(2), EXPO_MAX);
        send_operands(BASE_W'(2), EXPO_W'(1) << (EXPO_W - 1));
        // fermat: 2^(p-1) is 1
        send_operands(BASE_W'(2), EXPO_W'(PRIME) - EXPO_W'(1));
        // p-1 is -1, so even powers give 1 and odd ones p-1
        send_operands(BASE_P1 - BASE_W'(1), EXPO_W'(2));
        send_operands(BASE_P1 - BASE_W'(1), EXPO_MAX);
        send_operands(BASE_W'({16{2'b10}}), EXPO_W'({32{2'b01}}));
        send_operands(BASE_W'({16{2'b01}}), EXPO_W'({32{2'b10}}));
    endtask

    // bases that reduce to zero give 0 for any nonzero exponent, plus bases next to a multiple
    task automatic test_prime_multiples();
        send_operands(BASE_P1, EXPO_W'(1));
        send_operands(BASE_P2, EXPO_W'(1));
        send_operands(BASE_P1, EXPO_MAX);
        send_operands(BASE_P2, rand_exponent() | EXPO_W'(1));
        // one above a multiple reduces to 1
        send_operands(BASE_P1 + BASE_W'(1), EXPO_MAX);
        send_operands(BASE_P2 + BASE_W'(1), rand_exponent());
        send_operands(BASE_P2 - BASE_W'(1), EXPO_W'(3));
    endtask

    // random operands with a spread of exponent lengths and bases near multiples of p
    task automatic test_random_operands(input int count);
        logic [BASE_W-1:0] base;
        logic [EXPO_W-1:0] exponent;
        int unsigned       len;
        int                near;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: base = BASE_W'($urandom);
                1: begin
                    // within two of 0, p or 2p
                    near = int'($urandom_range(0, 2)) * int'(PRIME)
                           + int'($urandom_range(0, 4)) - 2;
                    base = (near < 0) ? BASE_W'(0) : BASE_W'(near);
                end
                2: base = BASE_W'($urandom_range(0, 3));
                default: base = BASE_MAX - BASE_W'($urandom_range(0, 3));
            endcase
            len = $urandom_range(1, EXPO_W);
            case ($urandom_range(0, 4))
                0: exponent = rand_exponent();
                // random bits below a set top bit of random position
                1: exponent = (rand_exponent() >> (EXPO_W - len))
                              | (EXPO_W'(1) << (len - 1));
                2: exponent = EXPO_W'($urandom_range(0, 16));
                // dense: all ones up to the length
                3: exponent = EXPO_MAX >> (EXPO_W - len);
                // sparse: one set bit
                default: exponent = EXPO_W'(1) << (len - 1);
            endcase
            send_operands(base, exponent);
        end
    endtask

    // result side: random ready bursts while idling is on
    initial begin : result_ready_gen
        int unsigned burst;
        forever begin
            @(posedge i_clk);
            if (idle_en && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 3);
                i_out_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // every result transfer is matched against the oldest owed power
    always @(posedge i_clk) begin
        logic [RES_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_powers.size() == 0) begin
                $error("result transfer with no item outstanding: result %0d", o_result);
                error_count <= error_count + 1;
            end else begin
                want = pending_powers.pop_front();
                if (o_result !== want) begin
                    $error("result mismatch: expected %0d, actual %0d", want, o_result);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results owed",
                     quiet_cycles, pending_powers.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // single synchronous reset at the start
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_exponent();
        test_field_extremes();
        test_prime_multiples();
        test_random_operands(730);
        // last stretch runs back to back on both sides
        idle_en = 1'b0;
        test_random_operands(100);
        i_in_valid <= 1'b0;

        while (pending_powers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
